// File: rtl/pidaw_pkg.sv
// Shared types, widths, register indexes and reset values of the PID controller.
package pidaw_pkg;

    localparam int unsigned SIG_W   = 32;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned GAIN_W  = 24;
    localparam int unsigned LIM_W   = 31;
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned CFG_W   = 31;
    localparam int unsigned CIDX_W  = 3;

    typedef enum logic [CIDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_OUT_LIM   = 3'd3,
        CFG_INT_LIM   = 3'd4,
        CFG_STEP_TIME = 3'd5,
        CFG_STEP_RATE = 3'd6
    } t_cfg_index;

    localparam logic [GAIN_W-1:0] RST_GAIN_P    = 24'd65536;
    localparam logic [GAIN_W-1:0] RST_GAIN_I    = 24'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_D    = 24'd0;
    localparam logic [LIM_W-1:0]  RST_OUT_LIM   = 31'd65536;
    localparam logic [LIM_W-1:0]  RST_INT_LIM   = 31'd196608;
    localparam logic [STEP_W-1:0] RST_STEP_TIME = 16'd3277;
    localparam logic [LIM_W-1:0]  RST_STEP_RATE = 31'd1310720;

    localparam logic signed [SIG_W-1:0] SIG_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SIG_W-1:0] SIG_MIN = 32'sh8000_0000;

endpackage

// File: rtl/pidaw_in_if.sv
// Input channel of the PID controller: setpoint, measurement and clear flag.
interface pidaw_in_if
    import pidaw_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [SIG_W-1:0] setpoint;
    logic signed [SIG_W-1:0] measured;
    logic                    clear_state;

    modport source (output valid, output setpoint, output measured, output clear_state,
                    input ready);
    modport sink   (input valid, input setpoint, input measured, input clear_state,
                    output ready);
endinterface

// File: rtl/pidaw_out_if.sv
// Output channel of the PID controller: the saturated drive value.
interface pidaw_out_if
    import pidaw_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [SIG_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// File: rtl/pid_controller_antiwindup.sv
// Top level of the PID controller with a clamped integral, built on one shared multiplier.
//
//   channel   direction  beat contents
//   i_in      sink       setpoint, measured, clear_state
//   o_out     source     drive
//   i_cfg_*   write      register index and data, no handshake
//
// A beat runs from acceptance in S_IDLE through S_ERR for the saturated error, S_M1 to
// S_M5 for five products on the single 33x32 signed multiplier (error*step_time,
// delta*step_rate, and the three gain products), S_ACC for one final add and S_OUT for
// the output clamp. The multiplier and its result register set this sequence.
// Reset (synchronous, active low) zeroes the integral and the last error and loads the
// register defaults. The result sits in an output register, so a new beat is taken while
// the last result still waits; a finished result only waits in the last state when the
// output register is still full.
module pid_controller_antiwindup
    import pidaw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    pidaw_in_if.sink           i_in,
    pidaw_out_if.source        o_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_M1, S_M2, S_M3, S_M4, S_M5, S_ACC, S_OUT
    } t_state;

    localparam int unsigned MA_W   = SIG_W + 1;
    localparam int unsigned MB_W   = SIG_W;
    localparam int unsigned PROD_W = MA_W + MB_W;
    localparam int unsigned ACC_W  = 60;
    localparam int unsigned DSH_W  = PROD_W - FRAC_W;
    localparam int unsigned ASH_W  = ACC_W - FRAC_W;

    localparam logic signed [DSH_W-1:0] D_MAX = DSH_W'(SIG_MAX);
    localparam logic signed [DSH_W-1:0] D_MIN = DSH_W'(SIG_MIN);

    t_state                   r_state;

    // Configuration registers.
    logic [GAIN_W-1:0]        r_gain_p, r_gain_i, r_gain_d;
    logic [LIM_W-1:0]         r_out_lim, r_int_lim, r_step_rate;
    logic [STEP_W-1:0]        r_step_time;

    // Controller state and working registers.
    logic signed [SIG_W-1:0]  r_integ, r_prev;
    logic signed [SIG_W-1:0]  r_sp, r_ms, r_err, r_deriv;
    logic signed [MA_W-1:0]   r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [SIG_W-1:0]  r_drive;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [SIG_W-1:0]  n_err, n_integ, n_deriv, n_drive;
    logic signed [MA_W-1:0]   n_diff;
    logic signed [MA_W-1:0]   err_wide, integ_sum, ilim_pos, ilim_neg;
    logic signed [SIG_W-1:0]  incr;
    logic signed [DSH_W-1:0]  deriv_sh;
    logic signed [ASH_W-1:0]  acc_sh, olim_pos, olim_neg;
    logic                     in_fire, out_free;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.drive = r_drive;

    // Operand selection for the shared multiplier; the product is registered in r_prod.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_M1: begin
                mul_a = MA_W'(r_err);
                mul_b = $signed(MB_W'(r_step_time));
            end
            S_M2: begin
                mul_a = r_diff;
                mul_b = $signed(MB_W'(r_step_rate));
            end
            S_M3: begin
                mul_a = MA_W'(r_err);
                mul_b = $signed(MB_W'(r_gain_p));
            end
            S_M4: begin
                mul_a = MA_W'(r_integ);
                mul_b = $signed(MB_W'(r_gain_i));
            end
            S_M5: begin
                mul_a = MA_W'(r_deriv);
                mul_b = $signed(MB_W'(r_gain_d));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = mul_a * mul_b;
    end

    always_comb begin
        // Error, saturated when the 33-bit difference leaves the signal range.
        err_wide = MA_W'(r_sp) - MA_W'(r_ms);
        if (err_wide[MA_W-1] != err_wide[MA_W-2]) begin
            n_err = err_wide[MA_W-1] ? SIG_MIN : SIG_MAX;
        end else begin
            n_err = err_wide[SIG_W-1:0];
        end

        n_diff = MA_W'(r_err) - MA_W'(r_prev);

        // Integral step: the floored increment always fits the signal width.
        incr      = r_prod[FRAC_W +: SIG_W];
        integ_sum = MA_W'(r_integ) + MA_W'(incr);
        ilim_pos  = $signed(MA_W'(r_int_lim));
        ilim_neg  = -ilim_pos;
        if (integ_sum > ilim_pos) begin
            n_integ = ilim_pos[SIG_W-1:0];
        end else if (integ_sum < ilim_neg) begin
            n_integ = ilim_neg[SIG_W-1:0];
        end else begin
            n_integ = integ_sum[SIG_W-1:0];
        end

        deriv_sh = r_prod[PROD_W-1:FRAC_W];
        if (deriv_sh > D_MAX) begin
            n_deriv = SIG_MAX;
        end else if (deriv_sh < D_MIN) begin
            n_deriv = SIG_MIN;
        end else begin
            n_deriv = deriv_sh[SIG_W-1:0];
        end

        acc_sh   = r_acc[ACC_W-1:FRAC_W];
        olim_pos = $signed(ASH_W'(r_out_lim));
        olim_neg = -olim_pos;
        if (acc_sh > olim_pos) begin
            n_drive = olim_pos[SIG_W-1:0];
        end else if (acc_sh < olim_neg) begin
            n_drive = olim_neg[SIG_W-1:0];
        end else begin
            n_drive = acc_sh[SIG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_prev      <= '0;
            r_gain_p    <= RST_GAIN_P;
            r_gain_i    <= RST_GAIN_I;
            r_gain_d    <= RST_GAIN_D;
            r_out_lim   <= RST_OUT_LIM;
            r_int_lim   <= RST_INT_LIM;
            r_step_time <= RST_STEP_TIME;
            r_step_rate <= RST_STEP_RATE;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GAIN_P:    r_gain_p    <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:    r_gain_i    <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:    r_gain_d    <= i_cfg_data[GAIN_W-1:0];
                    CFG_OUT_LIM:   r_out_lim   <= i_cfg_data[LIM_W-1:0];
                    CFG_INT_LIM:   r_int_lim   <= i_cfg_data[LIM_W-1:0];
                    CFG_STEP_TIME: r_step_time <= i_cfg_data[STEP_W-1:0];
                    CFG_STEP_RATE: r_step_rate <= i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end

            // A new result fills the output register, even in the cycle the old one leaves.
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            r_prod <= n_prod;

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_sp <= i_in.setpoint;
                        r_ms <= i_in.measured;
                        // A clear request wipes the history before this beat is used.
                        if (i_in.clear_state) begin
                            r_integ <= '0;
                            r_prev  <= '0;
                        end
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= n_err;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_diff  <= n_diff;
                    r_prev  <= r_err;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_integ <= n_integ;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_deriv <= n_deriv;
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_acc   <= r_prod[ACC_W-1:0];
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_acc   <= r_acc + r_prod[ACC_W-1:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= r_acc + r_prod[ACC_W-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Wait here only while the previous result has not been taken.
                    if (out_free) begin
                        r_drive <= n_drive;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // An accepted beat keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_in.ready)
        else $error("input accepted again right after a beat");

    // Right after the integral update the stored sum lies within its bound.
    a_integ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M3) |->
            (MA_W'(r_integ) <= $signed(MA_W'(r_int_lim)) &&
             MA_W'(r_integ) >= -$signed(MA_W'(r_int_lim))))
        else $error("integral sum outside its limit");

    // A fresh result never exceeds the output bound.
    a_drive_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=>
            (ASH_W'(r_drive) <= $signed(ASH_W'(r_out_lim)) &&
             ASH_W'(r_drive) >= -$signed(ASH_W'(r_out_lim)) && r_out_valid))
        else $error("drive outside its limit");

endmodule
